### src/epc_pkg.sv
// Shared types and constants for the encoder position P controller.
package epc_pkg;

  localparam int unsigned POS_WIDTH_DEF = 32;

  localparam logic [15:0] KP_GAIN_RST      = 16'd256;
  localparam logic [15:0] STOP_BAND_RST    = 16'd100;
  localparam logic [7:0]  MAX_SPEED_RST    = 8'd100;
  localparam logic [7:0]  MIN_SPEED_RST    = 8'd50;
  localparam logic [15:0] START_MARGIN_RST = 16'd20;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DRIVE = 2'd1,
    ACT_BRAKE = 2'd2
  } action_t;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] stop_band;
    logic [7:0]  max_speed;
    logic [7:0]  min_speed;
    logic [15:0] start_margin;
  } cfg_t;

  // One result item as it leaves the block.
  typedef struct packed {
    action_t            action;
    logic signed [8:0]  drive_speed;
    logic signed [31:0] position;
    logic signed [31:0] position_error;
    logic               seeking;
    logic               last;
  } res_t;

endpackage

### src/epc_cfg.sv
// Configuration register file of the position controller.
module epc_cfg
  import epc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  typedef enum logic [2:0] {
    REG_KP_GAIN      = 3'd0,
    REG_STOP_BAND    = 3'd1,
    REG_MAX_SPEED    = 3'd2,
    REG_MIN_SPEED    = 3'd3,
    REG_START_MARGIN = 3'd4
  } reg_idx_t;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_KP_GAIN:      cfg_nxt.kp_gain      = cfg_data;
        REG_STOP_BAND:    cfg_nxt.stop_band    = cfg_data;
        REG_MAX_SPEED:    cfg_nxt.max_speed    = cfg_data[7:0];
        REG_MIN_SPEED:    cfg_nxt.min_speed    = cfg_data[7:0];
        REG_START_MARGIN: cfg_nxt.start_margin = cfg_data;
        default:          cfg_nxt = cfg_r;  // writes past the list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain      <= KP_GAIN_RST;
      cfg_r.stop_band    <= STOP_BAND_RST;
      cfg_r.max_speed    <= MAX_SPEED_RST;
      cfg_r.min_speed    <= MIN_SPEED_RST;
      cfg_r.start_margin <= START_MARGIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/epc_ctrl.sv
// One proportional control step: error, scaled speed, clamp and brake decision.
module epc_ctrl
  import epc_pkg::*;
#(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  cfg_t                        cfg,
  input  logic                        seek_in,
  input  logic signed [POS_WIDTH-1:0] target,
  input  logic signed [POS_WIDTH-1:0] position,
  input  logic signed [POS_WIDTH-1:0] prev_err,
  output action_t                     action,
  output logic signed [8:0]           speed,
  output logic                        seek_out,
  output logic signed [POS_WIDTH-1:0] prev_err_out
);

  logic signed [POS_WIDTH-1:0] err;
  logic [POS_WIDTH-1:0]        emag;
  logic [23:0]                 emag_lo;
  logic [39:0]                 prod;
  logic [31:0]                 scaled;
  logic                        big;
  logic                        better;
  logic [7:0]                  smag_clamp;
  logic [7:0]                  smag;

  assign err     = target - position;
  assign better  = err < prev_err;
  assign emag    = err[POS_WIDTH-1] ? POS_WIDTH'(-err) : POS_WIDTH'(err);
  assign big     = (emag >> 24) != '0;
  assign emag_lo = 24'(emag);
  assign prod    = 40'(emag_lo) * 40'(cfg.kp_gain);
  assign scaled  = prod[39:8];

  always_comb begin
    if (big && (cfg.kp_gain != '0)) begin
      smag_clamp = cfg.max_speed;
    end else if (scaled > 32'(cfg.max_speed)) begin
      smag_clamp = cfg.max_speed;
    end else begin
      smag_clamp = scaled[7:0];
    end
    // small nonzero speeds are lifted to the minimum; zero stays zero
    if ((smag_clamp != '0) && (smag_clamp <= cfg.min_speed)) begin
      smag = cfg.min_speed;
    end else begin
      smag = smag_clamp;
    end
  end

  always_comb begin
    action       = ACT_NONE;
    speed        = '0;
    seek_out     = seek_in;
    prev_err_out = prev_err;
    if (seek_in) begin
      if ((emag <= POS_WIDTH'(cfg.stop_band)) || !better) begin
        action   = ACT_BRAKE;
        seek_out = 1'b0;
      end else begin
        action       = ACT_DRIVE;
        prev_err_out = err;
        // drive against the sign of the error
        speed = err[POS_WIDTH-1] ? $signed({1'b0, smag}) : -$signed({1'b0, smag});
      end
    end
  end

endmodule

### src/epc_out_buf.sv
// Two-slot result buffer: holds one or two result items and hands them out in order.
module epc_out_buf
  import epc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  logic load_two,
  input  res_t res0,
  input  res_t res1,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  res_t       slot0_r;
  res_t       slot1_r;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_valid = cnt_r != 2'd0;
  assign out_res   = slot0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = load_two ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0_r <= res0;
      slot1_r <= res1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

### src/encoder_position_p_controller_unit.sv
// Top level of the encoder position P controller.
//
// Input items arrive on in_* (opcode in in_tuser, encoder count, move distance
// and manual speed in in_tdata) and are accepted on in_tvalid & in_tready.
// Each item is registered, processed combinationally against the held position
// state, and its results are loaded into a two-entry result buffer.
// A relative move gives two result items (the second with out_tlast set);
// every other opcode gives one. Results leave on out_*, action in out_tuser.
// An accepted item passes through the input register and the result buffer
// before its first result shows. Throughput: one item per cycle while out_tready
// is high; a move's two results leave one after the other, and the next item waits.
// When out_tready is low the result buffer holds, the input register fills,
// and in_tready drops; no item is lost or repeated.
// Configuration writes (cfg_valid, always ready) are taken any cycle and must
// only happen while the block is idle.
// Reset (rst_n low, synchronous) restores register defaults, clears position,
// offset, target and previous error, and ends any move.
module encoder_position_p_controller_unit
  import epc_pkg::*;
#(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // raw_position, move_delta, manual_speed, zero pad
  input  logic [2:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // drive_speed, position, position_error, seeking, pad
  output logic [1:0]  out_tuser,  // action
  output logic        out_tlast
);

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_MOVE   = 3'd1,
    OP_BRAKE  = 3'd2,
    OP_MANUAL = 3'd3,
    OP_ZERO   = 3'd4
  } opcode_t;

  typedef logic signed [POS_WIDTH-1:0] pos_t;

  cfg_t cfg;

  // input register
  logic               vld_r;
  logic [2:0]         op_r;
  logic signed [31:0] raw_r;
  logic signed [31:0] delta_r;
  logic signed [8:0]  manual_r;

  // position state
  pos_t zero_off_r, zero_off_nxt;
  pos_t pos_r, pos_nxt;
  pos_t target_r, target_nxt;
  pos_t prev_r, prev_nxt;
  logic seek_r, seek_nxt;

  logic in_acc;
  logic advance;
  logic can_load;
  logic load_two;
  res_t res0, res1, out_res;

  pos_t              raw_w, delta_w, pos_s, tgt_move, prev_seed;
  action_t           act_a, act_b;
  logic signed [8:0] spd_a, spd_b, man_spd;
  logic              seek_a, seek_b;
  pos_t              prev_a, prev_b;

  epc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = !vld_r || can_load;
  assign advance   = vld_r && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_acc) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw_r    <= $signed(in_tdata[31:0]);
      delta_r  <= $signed(in_tdata[63:32]);
      manual_r <= $signed(in_tdata[72:64]);
      op_r     <= in_tuser;
    end
  end

  assign raw_w     = POS_WIDTH'(raw_r);
  assign delta_w   = POS_WIDTH'(delta_r);
  assign pos_s     = raw_w - zero_off_r;
  assign tgt_move  = pos_s + delta_w;
  assign prev_seed = delta_w + POS_WIDTH'(cfg.start_margin);
  assign man_spd   = (manual_r == -9'sd256) ? -9'sd255 : manual_r;

  // step against the current target
  epc_ctrl #(.POS_WIDTH(POS_WIDTH)) u_ctrl_a (
    .cfg          (cfg),
    .seek_in      (seek_r),
    .target       (target_r),
    .position     (pos_s),
    .prev_err     (prev_r),
    .action       (act_a),
    .speed        (spd_a),
    .seek_out     (seek_a),
    .prev_err_out (prev_a)
  );

  // step against a freshly set move target
  epc_ctrl #(.POS_WIDTH(POS_WIDTH)) u_ctrl_b (
    .cfg          (cfg),
    .seek_in      (1'b1),
    .target       (tgt_move),
    .position     (pos_s),
    .prev_err     (prev_seed),
    .action       (act_b),
    .speed        (spd_b),
    .seek_out     (seek_b),
    .prev_err_out (prev_b)
  );

  always_comb begin
    zero_off_nxt = zero_off_r;
    pos_nxt      = pos_r;
    target_nxt   = target_r;
    prev_nxt     = prev_r;
    seek_nxt     = seek_r;
    load_two     = 1'b0;

    res0.action         = ACT_NONE;
    res0.drive_speed    = '0;
    res0.position       = 32'(pos_r);
    res0.position_error = 32'(pos_t'(target_r - pos_r));
    res0.seeking        = seek_r;
    res0.last           = 1'b1;

    res1.action         = act_b;
    res1.drive_speed    = spd_b;
    res1.position       = 32'(pos_s);
    res1.position_error = 32'(pos_t'(tgt_move - pos_s));
    res1.seeking        = seek_b;
    res1.last           = 1'b1;

    case (op_r)
      OP_SAMPLE, OP_MOVE: begin
        pos_nxt             = pos_s;
        prev_nxt            = prev_a;
        seek_nxt            = seek_a;
        res0.action         = act_a;
        res0.drive_speed    = spd_a;
        res0.position       = 32'(pos_s);
        res0.position_error = 32'(pos_t'(target_r - pos_s));
        res0.seeking        = seek_a;
        if (op_r == OP_MOVE) begin
          load_two   = 1'b1;
          res0.last  = 1'b0;
          target_nxt = tgt_move;
          prev_nxt   = prev_b;
          seek_nxt   = seek_b;
        end
      end
      OP_BRAKE: begin
        seek_nxt     = 1'b0;
        res0.action  = ACT_BRAKE;
        res0.seeking = 1'b0;
      end
      OP_MANUAL: begin
        res0.action      = ACT_DRIVE;
        res0.drive_speed = man_spd;
      end
      OP_ZERO: begin
        zero_off_nxt = raw_w;
      end
      default: begin
        // unknown opcodes report the current state only
        res0.action = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_off_r <= '0;
      pos_r      <= '0;
      target_r   <= '0;
      prev_r     <= '0;
      seek_r     <= 1'b0;
    end else if (advance) begin
      zero_off_r <= zero_off_nxt;
      pos_r      <= pos_nxt;
      target_r   <= target_nxt;
      prev_r     <= prev_nxt;
      seek_r     <= seek_nxt;
    end
  end

  epc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .load_two  (load_two),
    .res0      (res0),
    .res1      (res1),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tuser = out_res.action;
  assign out_tlast = out_res.last;
  assign out_tdata = {6'b0, out_res.seeking, out_res.position_error,
                      out_res.position, out_res.drive_speed};

endmodule
